@@ hdl/hcv_pkg.sv @@
package hcv_pkg;

  // Colour windows and vote sizes.
  localparam int NUM_COLOURS    = 6;
  localparam int COUNT_BITS_DEF = 20;
  localparam int WIN_W          = 48;
  localparam int THR_W          = 20;
  localparam int CFG_IDX_W      = 3;
  localparam int WCNT_W         = 20;

  localparam logic [WCNT_W-1:0] WCNT_MAX = {WCNT_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORANGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PURPLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd6;

  // Class codes.
  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_MAX  = 3'd6;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        pixel_class;
    logic              winner_valid;
    logic [2:0]        winner;
    logic [WCNT_W-1:0] winner_count;
  } out_item_t;

  // Request travelling down the row of colour cells.
  typedef struct packed {
    logic       valid;
    in_item_t   item;
    logic [2:0] cls;
    logic [2:0] win;
  } token_t;

endpackage

@@ hdl/hcv_cell.sv @@
module hcv_cell #(
  parameter int         COUNT_BITS = hcv_pkg::COUNT_BITS_DEF,
  parameter logic [2:0] CODE       = 3'd1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      win_we,
  input  logic [hcv_pkg::WIN_W-1:0] win_data,
  input  logic [hcv_pkg::THR_W-1:0] thr,
  input  hcv_pkg::token_t           tok_i,
  input  logic [COUNT_BITS-1:0]     best_i,
  output hcv_pkg::token_t           tok_o,
  output logic [COUNT_BITS-1:0]     best_o
);

  logic [hcv_pkg::WIN_W-1:0] win_r;
  logic [COUNT_BITS-1:0]     cnt_r;
  logic [COUNT_BITS-1:0]     cnt_nxt;
  hcv_pkg::token_t           tok_r;
  hcv_pkg::token_t           tok_nxt;
  logic [COUNT_BITS-1:0]     best_r;
  logic [COUNT_BITS-1:0]     best_nxt;
  logic                      holds;
  logic                      hit;
  logic                      qual;
  logic [COUNT_BITS-1:0]     cand;

  // Strict open window on all three channels.
  assign holds = (win_r[7:0]   < tok_i.item.hue)        && (tok_i.item.hue < win_r[15:8]) &&
                 (win_r[23:16] < tok_i.item.saturation) &&
                 (tok_i.item.saturation < win_r[31:24]) &&
                 (win_r[39:32] < tok_i.item.brightness) &&
                 (tok_i.item.brightness < win_r[47:40]);

  // Only the first matching colour claims the pixel.
  assign hit  = tok_i.valid && (tok_i.cls == hcv_pkg::CLS_NONE) && holds;
  assign cand = (hit && (cnt_r != {COUNT_BITS{1'b1}})) ? cnt_r + 1'b1 : cnt_r;

  // Vote: strictly above threshold and strictly above the earlier colours.
  assign qual = tok_i.item.last && (32'(cand) > 32'(thr)) && (cand > best_i);

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.cls = hit  ? CODE : tok_i.cls;
    tok_nxt.win = qual ? CODE : tok_i.win;
    best_nxt    = qual ? cand : best_i;
    cnt_nxt     = cnt_r;
    if (tok_i.valid) begin
      cnt_nxt = tok_i.item.last ? '0 : cand;
    end
  end

  // Window register and counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
    end else begin
      if (win_we) begin
        win_r <= win_data;
      end
      if (adv) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Stage register towards the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      best_r <= '0;
    end else if (adv) begin
      tok_r  <= tok_nxt;
      best_r <= best_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign best_o = best_r;

  // A token that leaves the cell with this colour as winner had its last flag set.
  a_win_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tok_i.valid && qual) |=> (tok_r.item.last && tok_r.win == CODE))
    else $error("winner set on a pixel that is not last");

  // The counter is empty after a last pixel passes.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tok_i.valid && tok_i.item.last) |=> (cnt_r == '0))
    else $error("counter not cleared after region end");

endmodule

@@ hdl/hcv_out_buf.sv @@
module hcv_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hcv_pkg::out_item_t push_data,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output hcv_pkg::out_item_t out_data
);

  logic               out_valid_r;
  hcv_pkg::out_item_t out_data_r;
  logic               skid_valid_r;
  hcv_pkg::out_item_t skid_data_r;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_ready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign room      = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid entry is only ever filled behind a held output.
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds data while output is empty");

  // No push arrives while the skid entry is occupied.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("push into full output buffer");

endmodule

@@ hdl/hsv_color_class_vote_unit.sv @@
// Channel  Direction  Handshake              Payload
// in_      in         in_valid / in_ready    hcv_pkg::in_item_t (pixel, last flag)
// out_     out        out_valid / out_ready  hcv_pkg::out_item_t (class, vote)
// cfg_     in         cfg_valid / cfg_ready  cfg_index (register), cfg_data (48 bits)
//
// One pixel is taken per clock while in_ready is high; a request passes the six cell
// stages and then the output register before it reaches out_valid. The row of six colour
// cells, one pipeline stage each, feeds an output register with a single skid entry.
// Reset (synchronous, rst_n low) clears all windows, the threshold and the counters.
// in_ready drops only while the skid entry is full; the whole row then holds.
// cfg_ready is always high.
module hsv_color_class_vote_unit #(
  parameter int COUNT_BITS = hcv_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hcv_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hcv_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hcv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hcv_pkg::WIN_W-1:0]     cfg_data
);

  localparam int N = hcv_pkg::NUM_COLOURS;

  hcv_pkg::token_t           tok [0:N];
  logic [COUNT_BITS-1:0]     best [0:N];
  logic [hcv_pkg::THR_W-1:0] thr_r;
  logic                      adv;
  logic [31:0]               best_ext;
  hcv_pkg::out_item_t        res;

  assign cfg_ready = 1'b1;
  assign in_ready  = adv;

  // Count threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_index == hcv_pkg::REG_THRESH) begin
      thr_r <= cfg_data[hcv_pkg::THR_W-1:0];
    end
  end

  // Head of the row: a fresh request with no class and no vote yet.
  always_comb begin
    tok[0].valid = in_valid;
    tok[0].item  = in_data;
    tok[0].cls   = hcv_pkg::CLS_NONE;
    tok[0].win   = hcv_pkg::CLS_NONE;
    best[0]      = '0;
  end

  // Row of colour cells in priority order.
  for (genvar k = 0; k < N; k++) begin : g_cell
    hcv_cell #(
      .COUNT_BITS (COUNT_BITS),
      .CODE       (3'(k + 1))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .win_we   (cfg_valid && cfg_index == hcv_pkg::CFG_IDX_W'(k)),
      .win_data (cfg_data),
      .thr      (thr_r),
      .tok_i    (tok[k]),
      .best_i   (best[k]),
      .tok_o    (tok[k+1]),
      .best_o   (best[k+1])
    );
  end

  // Form the result; the winner count saturates at the field width.
  assign best_ext = 32'(best[N]);

  always_comb begin
    res.pixel_class  = tok[N].cls;
    res.winner_valid = tok[N].item.last;
    res.winner       = tok[N].win;
    res.winner_count = (best_ext > 32'(hcv_pkg::WCNT_MAX)) ? hcv_pkg::WCNT_MAX
                                                           : best_ext[hcv_pkg::WCNT_W-1:0];
  end

  hcv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && tok[N].valid),
    .push_data (res),
    .room      (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A result that does not close a region carries no vote.
  a_no_vote: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.winner_valid) |->
      (out_data.winner == hcv_pkg::CLS_NONE && out_data.winner_count == '0))
    else $error("vote reported on a pixel that is not last");

  // Class and winner codes stay within the colour list.
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_class <= hcv_pkg::CLS_MAX &&
                   out_data.winner <= hcv_pkg::CLS_MAX))
    else $error("class code out of range");

  // No winner means no count, and a winner has a nonzero count.
  a_win_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.winner == hcv_pkg::CLS_NONE) == (out_data.winner_count == '0)))
    else $error("winner and winner count disagree");

endmodule
